### rtl/cirb_pkg.sv
// ----------------------------------------------------------------------------
// cirb_pkg
// Shared types, register map and constants of the console I/O register block.
// ----------------------------------------------------------------------------
package cirb_pkg;

  localparam int DATA_W     = 32;
  localparam int IDX_W      = 8;
  localparam int REG_WORDS  = 256;
  localparam int OTP_WORDS  = 32;
  localparam int SLOT_W     = $clog2(REG_WORDS);
  localparam int OTP_ADDR_W = $clog2(OTP_WORDS);

  typedef logic [DATA_W-1:0]     word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [OTP_ADDR_W-1:0] otp_addr_t;

  // Register map, in word offsets
  localparam idx_t IDX_TIMER    = 8'd4;
  localparam idx_t IDX_PROTECT  = 8'd24;
  localparam idx_t IDX_GPIO_EN  = 8'd55;
  localparam idx_t IDX_GPIO_OUT = 8'd56;
  localparam idx_t IDX_GPIO_DIR = 8'd57;
  localparam idx_t IDX_GPIO_IN  = 8'd58;
  localparam idx_t IDX_SPARE    = 8'd98;
  localparam idx_t IDX_BOOT     = 8'd99;
  localparam idx_t IDX_OTP_CMD  = 8'd123;
  localparam idx_t IDX_OTP_DATA = 8'd124;
  localparam idx_t IDX_VERSION  = 8'd133;

  localparam word_t VERSION_WORD     = 32'h0000_0010;
  localparam word_t OTP_INDEX_MASK   = 32'h0000_001f;
  localparam word_t BOOT_CLEAR_VALUE = 32'd0;
  localparam word_t BOOT_SET_VALUE   = 32'd9;
  localparam int    OTP_GO_BIT       = 31;
  localparam int    BOOT_SEL_BIT     = 16;
  localparam word_t OTP_LATCH_RESET  = 32'hffff_ffff;

  localparam slot_t BOOT_SLOT  = SLOT_W'(int'(IDX_BOOT) % REG_WORDS);
  localparam slot_t SPARE_SLOT = SLOT_W'(int'(IDX_SPARE) % REG_WORDS);

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_TICK     = 2'd2,
    OP_OTP_LOAD = 2'd3
  } op_t;

  // One write into the general word store
  typedef struct packed {
    logic  en;
    slot_t slot;
    word_t data;
  } store_wr_t;

  // Word index wraps modulo the store depth (a power of two)
  function automatic slot_t store_slot(idx_t idx);
    return SLOT_W'(idx);
  endfunction

endpackage

### rtl/cirb_ram.sv
// ----------------------------------------------------------------------------
// cirb_ram
// Generic single write port RAM with one registered read port (read-first).
// ----------------------------------------------------------------------------
module cirb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/cirb_otp.sv
// ----------------------------------------------------------------------------
// cirb_otp
// OTP word store: loaded one word at a time, read by the OTP command.
// ----------------------------------------------------------------------------
module cirb_otp import cirb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  otp_addr_t wr_slot,
  input  word_t     wr_data,
  input  otp_addr_t rd_slot,
  output word_t     rd_word
);

  word_t otp_mem [OTP_WORDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < OTP_WORDS; i++) begin
        otp_mem[i] <= '0;
      end
    end else if (wr_en) begin
      otp_mem[wr_slot] <= wr_data;
    end
  end

  assign rd_word = otp_mem[rd_slot];

endmodule

### rtl/cirb_store.sv
// ----------------------------------------------------------------------------
// cirb_store
// General word store: RAM with per-word written flags and a bypass for the
// write that lands on the same edge as the read is issued.
// ----------------------------------------------------------------------------
module cirb_store import cirb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      rd_en,
  input  slot_t     rd_slot,
  input  slot_t     cur_slot,
  input  store_wr_t wr,
  output word_t     rd_word
);

  logic [REG_WORDS-1:0] written;
  logic                 fwd_valid;
  slot_t                fwd_slot;
  word_t                fwd_data;
  word_t                ram_q;

  cirb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(REG_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (wr.en),
    .waddr(wr.slot),
    .wdata(wr.data),
    .re   (rd_en),
    .raddr(rd_slot),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.slot] <= 1'b1;
    end
  end

  // Capture the write that races the read issue; hold it while the word waits
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (rd_en) begin
      fwd_valid <= wr.en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_slot <= wr.slot;
      fwd_data <= wr.data;
    end
  end

  always_comb begin
    if (fwd_valid && (fwd_slot == cur_slot)) begin
      rd_word = fwd_data;
    end else if (written[cur_slot]) begin
      rd_word = ram_q;
    end else begin
      rd_word = '0;
    end
  end

endmodule

### rtl/console_io_register_block_core.sv
// ----------------------------------------------------------------------------
// console_io_register_block_core
// 32-bit register block: reads, writes, timer ticks and OTP word loads.
// ----------------------------------------------------------------------------
// One word is accepted every cycle while the input is not stalled. A word is
// registered on acceptance and executed from the execute stage; a read returns
// its data from the result register in the cycle after it executes. The input
// stalls only when a read reaches execution while the result register is still
// full and not being taken. The general word store is a RAM with one write
// port and one registered read port; the read is issued on acceptance, and a
// write that lands on the same edge is forwarded. Written flags per word stand
// in for its cleared reset, so no clearing pass is needed after reset. Unmapped
// offsets wrap modulo the store depth; the boot word is kept in its own register.
module console_io_register_block_core import cirb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            operation,
  input  logic [IDX_W-1:0]      word_index,
  input  logic [DATA_W-1:0]     write_data,
  input  logic [OTP_ADDR_W-1:0] otp_slot,
  input  logic [DATA_W-1:0]     otp_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_W-1:0]     read_data
);

  // Execute stage
  logic      s1_valid;
  op_t       s1_op;
  idx_t      s1_idx;
  word_t     s1_data;
  otp_addr_t s1_otp_slot;
  word_t     s1_otp_word;
  logic      s1_go;
  logic      accept;
  slot_t     s1_slot;

  // Named registers
  word_t protect_word;
  word_t otp_latch;
  word_t pin_enable;
  word_t pin_direction;
  word_t pin_value;
  word_t tick_count;
  word_t boot_word;

  word_t     store_word;
  word_t     otp_rd_word;
  word_t     rd_value;
  store_wr_t store_wr;
  logic      do_write;

  assign s1_go    = s1_valid && ((s1_op != OP_READ) || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;
  assign accept   = in_valid && in_ready;
  assign s1_slot  = store_slot(s1_idx);
  assign do_write = s1_go && (s1_op == OP_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= op_t'(operation);
      s1_idx      <= word_index;
      s1_data     <= write_data;
      s1_otp_slot <= otp_slot;
      s1_otp_word <= otp_word;
    end
  end

  cirb_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_slot (store_slot(word_index)),
    .cur_slot(s1_slot),
    .wr      (store_wr),
    .rd_word (store_word)
  );

  cirb_otp u_otp (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (s1_go && (s1_op == OP_OTP_LOAD)),
    .wr_slot(s1_otp_slot),
    .wr_data(s1_otp_word),
    .rd_slot(OTP_ADDR_W'(s1_data & OTP_INDEX_MASK)),
    .rd_word(otp_rd_word)
  );

  // Store write: spare, unmapped and read-only offsets; the boot slot stays in boot_word
  always_comb begin
    store_wr.en   = 1'b0;
    store_wr.slot = s1_slot;
    store_wr.data = s1_data;
    case (s1_idx)
      IDX_PROTECT, IDX_OTP_CMD, IDX_GPIO_EN, IDX_GPIO_DIR, IDX_GPIO_OUT: begin
        store_wr.en = 1'b0;
      end
      default: begin
        store_wr.en = do_write && (s1_slot != BOOT_SLOT);
      end
    endcase
  end

  always_comb begin
    case (s1_idx)
      IDX_PROTECT:  rd_value = protect_word;
      IDX_OTP_DATA: rd_value = otp_latch;
      IDX_GPIO_EN:  rd_value = pin_enable;
      IDX_GPIO_DIR: rd_value = pin_direction;
      IDX_GPIO_OUT: rd_value = pin_value & pin_direction;
      IDX_GPIO_IN:  rd_value = pin_value & ~pin_direction;
      IDX_TIMER:    rd_value = tick_count;
      IDX_VERSION:  rd_value = VERSION_WORD;
      default:      rd_value = (s1_slot == BOOT_SLOT) ? boot_word : store_word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      protect_word  <= '0;
      otp_latch     <= OTP_LATCH_RESET;
      pin_enable    <= '0;
      pin_direction <= '0;
      pin_value     <= '0;
      boot_word     <= '0;
    end else if (do_write) begin
      case (s1_idx)
        IDX_PROTECT: protect_word <= s1_data;
        IDX_OTP_CMD: begin
          if (s1_data[OTP_GO_BIT]) begin
            otp_latch <= otp_rd_word;
          end
        end
        IDX_GPIO_EN:  pin_enable    <= s1_data;
        IDX_GPIO_DIR: pin_direction <= s1_data;
        IDX_GPIO_OUT: pin_value     <= s1_data & pin_enable & pin_direction;
        IDX_SPARE: begin
          boot_word <= s1_data[BOOT_SEL_BIT] ? BOOT_CLEAR_VALUE : BOOT_SET_VALUE;
        end
        default: begin
          if (s1_slot == BOOT_SLOT) begin
            boot_word <= s1_data;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (s1_go && (s1_op == OP_TICK)) begin
      tick_count <= tick_count + 32'd1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && (s1_op == OP_READ)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_op == OP_READ)) begin
      read_data <= rd_value;
    end
  end

  a_empty_takes_word: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input not ready while execute stage is empty");

  a_stall_only_on_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |-> (out_valid && !out_ready))
    else $error("execute stage stalled without a blocked result");

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s1_go && (s1_op == OP_READ)) |=> out_valid)
    else $error("executed read produced no result");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    (s1_go && (s1_op == OP_TICK)) |=> (tick_count == $past(tick_count) + 32'd1))
    else $error("timer tick did not advance the counter");

endmodule
